// ===== sv/bmp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_pkg
// Shared types and constants for the BMP 24-bit to RGB565 stream converter.
// ----------------------------------------------------------------------------
package bmp_pkg;

	localparam int BYTE_W  = 8;
	localparam int DIM_W   = 11;
	localparam int COORD_W = 10;
	localparam int COLOR_W = 16;
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;

	localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
	localparam logic [15:0] BMP_PLANES    = 16'd1;
	localparam logic [15:0] BMP_DEPTH     = 16'd24;
	localparam logic [31:0] HEADER_LEN    = 32'd34;

	// header byte positions
	localparam logic [31:0] IDX_SIG_LO   = 32'd0;
	localparam logic [31:0] IDX_SIG_HI   = 32'd1;
	localparam logic [31:0] IDX_OFF_LO   = 32'd10;
	localparam logic [31:0] IDX_OFF_HI   = 32'd13;
	localparam logic [31:0] IDX_W_LO     = 32'd18;
	localparam logic [31:0] IDX_W_HI     = 32'd21;
	localparam logic [31:0] IDX_H_LO     = 32'd22;
	localparam logic [31:0] IDX_H_HI     = 32'd25;
	localparam logic [31:0] IDX_PLN_LO   = 32'd26;
	localparam logic [31:0] IDX_PLN_HI   = 32'd27;
	localparam logic [31:0] IDX_BPP_LO   = 32'd28;
	localparam logic [31:0] IDX_BPP_HI   = 32'd29;
	localparam logic [31:0] IDX_CMP_LO   = 32'd30;
	localparam logic [31:0] IDX_CMP_HI   = 32'd33;

	localparam logic [1:0] LANE_BLUE  = 2'd0;
	localparam logic [1:0] LANE_GREEN = 2'd1;
	localparam logic [1:0] LANE_RED   = 2'd2;

	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_ERROR = 1'b1;

	localparam logic REG_SCREEN_W = 1'b0;
	localparam logic REG_SCREEN_H = 1'b1;

	localparam logic [DIM_W-1:0] SCREEN_W_RST = 11'd320;
	localparam logic [DIM_W-1:0] SCREEN_H_RST = 11'd240;

	typedef enum logic [3:0] {
		PH_HEADER = 4'b0001,
		PH_SKIP   = 4'b0010,
		PH_PIXELS = 4'b0100,
		PH_DONE   = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [DIM_W-1:0] screen_w;
		logic [DIM_W-1:0] screen_h;
	} cfg_t;

	typedef struct packed {
		logic               kind;
		logic [COORD_W-1:0] pixel_x;
		logic [COORD_W-1:0] pixel_y;
		logic [COLOR_W-1:0] color;
	} res_t;

	typedef struct packed {
		logic load;
		logic vld;
		res_t res;
	} res_bus_t;

endpackage

// ===== sv/bmp_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_in_if
// Byte stream channel: one file byte per word plus a start-of-file flag.
// ----------------------------------------------------------------------------
interface bmp_in_if
	import bmp_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              start_of_file;

	modport source (output valid, output data_byte, output start_of_file, input ready);
	modport sink   (input valid, input data_byte, input start_of_file, output ready);
endinterface

// ===== sv/bmp_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_out_if
// Result channel: RGB565 pixel with screen coordinates, or a header error.
// ----------------------------------------------------------------------------
interface bmp_out_if
	import bmp_pkg::*;
	();
	logic               valid;
	logic               ready;
	logic               kind;
	logic [COORD_W-1:0] pixel_x;
	logic [COORD_W-1:0] pixel_y;
	logic [COLOR_W-1:0] color;

	modport source (output valid, output kind, output pixel_x, output pixel_y,
		output color, input ready);
	modport sink   (input valid, input kind, input pixel_x, input pixel_y,
		input color, output ready);
endinterface

// ===== sv/bmp_apb_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_apb_regs
// APB register file holding the screen width and height used for cropping.
// ----------------------------------------------------------------------------
module bmp_apb_regs
	import bmp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [DIM_W-1:0] screen_w_q;
	logic [DIM_W-1:0] screen_h_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_w_q <= SCREEN_W_RST;
			screen_h_q <= SCREEN_H_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_SCREEN_W: screen_w_q <= pwdata[DIM_W-1:0];
				REG_SCREEN_H: screen_h_q <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_SCREEN_W: prdata = {{(APB_DW-DIM_W){1'b0}}, screen_w_q};
			REG_SCREEN_H: prdata = {{(APB_DW-DIM_W){1'b0}}, screen_h_q};
			default:      prdata = '0;
		endcase
	end

	assign cfg.screen_w = screen_w_q;
	assign cfg.screen_h = screen_h_q;

endmodule

// ===== sv/bmp_parse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_parse
// Input word register and single-pass BMP parser: header checks, offset skip,
// padded row walk, cropping and RGB565 packing.
// ----------------------------------------------------------------------------
module bmp_parse
	import bmp_pkg::*;
#(
	parameter int MAX_SCREEN_DIM = 1024
)(
	input  logic     clk,
	input  logic     arst_n,
	bmp_in_if.sink   in_ch,
	input  cfg_t     cfg,
	input  logic     out_free,
	output res_bus_t bus
);

	localparam int MD_W = $clog2(MAX_SCREEN_DIM + 1);
	localparam int CW   = (MD_W > DIM_W) ? MD_W : DIM_W;
	localparam logic [CW-1:0] MAX_DIM = CW'(MAX_SCREEN_DIM);

	// input stage
	logic              valid_s1;
	logic [BYTE_W-1:0] data_s1;
	logic              sof_s1;
	logic              advance;

	// parser state
	phase_t      phase_q, phase_c, phase_n;
	logic [31:0] byte_cnt_q, byte_cnt_c, byte_cnt_n;
	logic [31:0] pix_off_q, pix_off_c, pix_off_n;
	logic [31:0] img_w_q, img_w_c, img_w_n;
	logic [31:0] img_h_q, img_h_c, img_h_n;
	logic [31:0] mag_q, mag_c, mag_n;
	logic        top_down_q, top_down_c, top_down_n;
	logic [31:0] file_row_q, file_row_c, file_row_n;
	logic [30:0] col_q, col_c, col_n;
	logic [1:0]  lane_q, lane_c, lane_n;
	logic        in_pad_q, in_pad_c, in_pad_n;
	logic [1:0]  pad_q, pad_c, pad_n;
	logic [15:0] held_q, held_c, held_n;
	logic        nz_q, nz_c, nz_n;

	logic [1:0]    fld_lane;
	logic          nz_hdr;
	logic [31:0]   h_mag;
	logic [CW-1:0] wc, hc;
	logic [31:0]   y_pos;
	logic [30:0]   col_inc;
	logic [31:0]   row_inc;
	logic          row_end;
	logic          res_vld;
	res_t          res;

	assign advance     = valid_s1 & out_free;
	assign in_ch.ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.valid && in_ch.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			data_s1 <= in_ch.data_byte;
			sof_s1  <= in_ch.start_of_file;
		end
	end

	// start of file clears the parser before the word is used
	always_comb begin
		if (sof_s1) begin
			phase_c    = PH_HEADER;
			byte_cnt_c = '0;
			pix_off_c  = '0;
			img_w_c    = '0;
			img_h_c    = '0;
			mag_c      = '0;
			top_down_c = 1'b0;
			file_row_c = '0;
			col_c      = '0;
			lane_c     = LANE_BLUE;
			in_pad_c   = 1'b0;
			pad_c      = '0;
			held_c     = '0;
			nz_c       = 1'b0;
		end else begin
			phase_c    = phase_q;
			byte_cnt_c = byte_cnt_q;
			pix_off_c  = pix_off_q;
			img_w_c    = img_w_q;
			img_h_c    = img_h_q;
			mag_c      = mag_q;
			top_down_c = top_down_q;
			file_row_c = file_row_q;
			col_c      = col_q;
			lane_c     = lane_q;
			in_pad_c   = in_pad_q;
			pad_c      = pad_q;
			held_c     = held_q;
			nz_c       = nz_q;
		end
	end

	assign wc = ({{(CW-DIM_W){1'b0}}, cfg.screen_w} > MAX_DIM) ? MAX_DIM
		: CW'(cfg.screen_w);
	assign hc = ({{(CW-DIM_W){1'b0}}, cfg.screen_h} > MAX_DIM) ? MAX_DIM
		: CW'(cfg.screen_h);

	assign fld_lane = byte_cnt_c[1:0] ^ 2'b10;
	assign nz_hdr   = ((byte_cnt_c == IDX_CMP_LO) ? 1'b0 : nz_c) | (data_s1 != '0);
	assign h_mag    = img_h_c[31] ? (32'd0 - img_h_c) : img_h_c;
	assign y_pos    = top_down_c ? file_row_c : (mag_c - 32'd1 - file_row_c);
	assign col_inc  = col_c + 31'd1;
	assign row_inc  = file_row_c + 32'd1;

	always_comb begin
		phase_n    = phase_c;
		byte_cnt_n = byte_cnt_c;
		pix_off_n  = pix_off_c;
		img_w_n    = img_w_c;
		img_h_n    = img_h_c;
		mag_n      = mag_c;
		top_down_n = top_down_c;
		file_row_n = file_row_c;
		col_n      = col_c;
		lane_n     = lane_c;
		in_pad_n   = in_pad_c;
		pad_n      = pad_c;
		held_n     = held_c;
		nz_n       = nz_c;
		row_end    = 1'b0;
		res_vld    = 1'b0;
		res        = '0;

		unique case (phase_c)
			PH_HEADER: begin
				byte_cnt_n = byte_cnt_c + 32'd1;
				if (byte_cnt_c == IDX_SIG_LO || byte_cnt_c == IDX_PLN_LO
					|| byte_cnt_c == IDX_BPP_LO) begin
					held_n = {8'h00, data_s1};
				end else if (byte_cnt_c == IDX_SIG_HI || byte_cnt_c == IDX_PLN_HI
					|| byte_cnt_c == IDX_BPP_HI) begin
					held_n = {data_s1, held_c[7:0]};
					if ((byte_cnt_c == IDX_SIG_HI && held_n != BMP_SIGNATURE)
						|| (byte_cnt_c == IDX_PLN_HI && held_n != BMP_PLANES)
						|| (byte_cnt_c == IDX_BPP_HI && held_n != BMP_DEPTH)) begin
						phase_n  = PH_DONE;
						res_vld  = 1'b1;
						res.kind = KIND_ERROR;
					end
				end else if (byte_cnt_c >= IDX_OFF_LO && byte_cnt_c <= IDX_OFF_HI) begin
					pix_off_n[{fld_lane, 3'b000} +: 8] = data_s1;
				end else if (byte_cnt_c >= IDX_W_LO && byte_cnt_c <= IDX_W_HI) begin
					img_w_n[{fld_lane, 3'b000} +: 8] = data_s1;
				end else if (byte_cnt_c >= IDX_H_LO && byte_cnt_c <= IDX_H_HI) begin
					img_h_n[{fld_lane, 3'b000} +: 8] = data_s1;
				end else if (byte_cnt_c >= IDX_CMP_LO && byte_cnt_c <= IDX_CMP_HI) begin
					nz_n = nz_hdr;
					if (byte_cnt_c == IDX_CMP_HI) begin
						if (nz_hdr) begin
							phase_n  = PH_DONE;
							res_vld  = 1'b1;
							res.kind = KIND_ERROR;
						end else begin
							held_n     = '0;
							top_down_n = img_h_c[31];
							mag_n      = h_mag;
							if (img_w_c == '0 || img_w_c[31] || img_h_c == '0) begin
								phase_n = PH_DONE;
							end else if (pix_off_c <= HEADER_LEN) begin
								phase_n = PH_PIXELS;
							end else begin
								phase_n = PH_SKIP;
							end
						end
					end
				end
			end
			PH_SKIP: begin
				if (byte_cnt_c != '1) begin
					byte_cnt_n = byte_cnt_c + 32'd1;
				end
				if (({1'b0, byte_cnt_c} + 33'd1 >= {1'b0, pix_off_c})
					|| byte_cnt_c == '1) begin
					phase_n = PH_PIXELS;
				end
			end
			PH_PIXELS: begin
				if (!in_pad_c) begin
					case (lane_c)
						LANE_BLUE: begin
							held_n = {held_c[15:8], data_s1};
							lane_n = LANE_GREEN;
						end
						LANE_GREEN: begin
							held_n = {data_s1, held_c[7:0]};
							lane_n = LANE_RED;
						end
						default: begin
							if ({1'b0, col_c} < {{(32-CW){1'b0}}, wc}
								&& y_pos < {{(32-CW){1'b0}}, hc}) begin
								res_vld     = 1'b1;
								res.kind    = KIND_PIXEL;
								res.pixel_x = col_c[COORD_W-1:0];
								res.pixel_y = y_pos[COORD_W-1:0];
								res.color   = {data_s1[7:3], held_c[15:10], held_c[7:3]};
							end
							lane_n = LANE_BLUE;
							col_n  = col_inc;
							if ({1'b0, col_inc} == img_w_c) begin
								if (img_w_c[1:0] == 2'd0) begin
									row_end = 1'b1;
								end else begin
									in_pad_n = 1'b1;
									pad_n    = '0;
								end
							end
						end
					endcase
				end else begin
					pad_n = pad_c + 2'd1;
					if (pad_n == img_w_c[1:0]) begin
						row_end = 1'b1;
					end
				end
				if (row_end) begin
					col_n      = '0;
					lane_n     = LANE_BLUE;
					in_pad_n   = 1'b0;
					pad_n      = '0;
					file_row_n = row_inc;
					if (row_inc >= mag_c) begin
						phase_n = PH_DONE;
					end
				end
			end
			PH_DONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			byte_cnt_q <= '0;
			pix_off_q  <= '0;
			img_w_q    <= '0;
			img_h_q    <= '0;
			mag_q      <= '0;
			top_down_q <= 1'b0;
			file_row_q <= '0;
			col_q      <= '0;
			lane_q     <= LANE_BLUE;
			in_pad_q   <= 1'b0;
			pad_q      <= '0;
			held_q     <= '0;
			nz_q       <= 1'b0;
		end else if (advance) begin
			phase_q    <= phase_n;
			byte_cnt_q <= byte_cnt_n;
			pix_off_q  <= pix_off_n;
			img_w_q    <= img_w_n;
			img_h_q    <= img_h_n;
			mag_q      <= mag_n;
			top_down_q <= top_down_n;
			file_row_q <= file_row_n;
			col_q      <= col_n;
			lane_q     <= lane_n;
			in_pad_q   <= in_pad_n;
			pad_q      <= pad_n;
			held_q     <= held_n;
			nz_q       <= nz_n;
		end
	end

	assign bus.load = advance;
	assign bus.vld  = res_vld;
	assign bus.res  = res;

	a_pix_geometry: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PIXELS) |-> (img_w_q != '0 && !img_w_q[31] && mag_q != '0))
		else $error("pixel phase entered with empty geometry");

	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PIXELS) |-> (file_row_q < mag_q))
		else $error("file row beyond image height");

	a_lane_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PIXELS) |-> (lane_q != 2'd3))
		else $error("byte lane out of range");

	a_pad_range: assert property (@(posedge clk) disable iff (!arst_n)
		in_pad_q |-> (pad_q < img_w_q[1:0] && lane_q == LANE_BLUE))
		else $error("row padding count out of range");

	a_pixel_src: assert property (@(posedge clk) disable iff (!arst_n)
		(bus.load && bus.vld && bus.res.kind == KIND_PIXEL)
			|-> (phase_c == PH_PIXELS && lane_c == LANE_RED && !in_pad_c))
		else $error("pixel word produced outside red byte");

endmodule

// ===== sv/bmp_outreg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_outreg
// Result register driving the output channel.
// ----------------------------------------------------------------------------
module bmp_outreg
	import bmp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  res_bus_t  bus,
	output logic      out_free,
	bmp_out_if.source out_ch
);

	logic valid_s2;
	res_t res_s2;

	assign out_free = ~valid_s2 | out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (bus.load) begin
			valid_s2 <= bus.vld;
		end else if (out_ch.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (bus.load && bus.vld) begin
			res_s2 <= bus.res;
		end
	end

	assign out_ch.valid   = valid_s2;
	assign out_ch.kind    = res_s2.kind;
	assign out_ch.pixel_x = res_s2.pixel_x;
	assign out_ch.pixel_y = res_s2.pixel_y;
	assign out_ch.color   = res_s2.color;

endmodule

// ===== sv/bmp24_stream_to_rgb565.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp24_stream_to_rgb565
// Parses a 24-bit BMP byte stream and emits cropped RGB565 pixels with
// screen coordinates, or one error word for a rejected header.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake       | payload
//  in_ch    | in  | valid/ready     | data_byte[7:0], start_of_file
//  out_ch   | out | valid/ready     | kind, pixel_x[9:0], pixel_y[9:0], color[15:0]
//  apb      | in  | psel/penable    | paddr[2:0], pwdata[31:0], prdata[31:0]
//
//  One byte per cycle unless out_ch stalls; input register, then result register.
//  Parsing is a single combinational pass between the input and result registers.
//  Reset: asynchronous, parser returns to header state, screen size 320x240.
//  A stalled result word holds the input register; the input side then stalls.
// ----------------------------------------------------------------------------
module bmp24_stream_to_rgb565
	import bmp_pkg::*;
#(
	parameter int MAX_SCREEN_DIM = 1024
)(
	input  logic              clk,
	input  logic              arst_n,
	bmp_in_if.sink            in_ch,
	bmp_out_if.source         out_ch,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	cfg_t     cfg;
	res_bus_t bus;
	logic     out_free;

	bmp_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bmp_parse #(
		.MAX_SCREEN_DIM (MAX_SCREEN_DIM)
	) u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.cfg      (cfg),
		.out_free (out_free),
		.bus      (bus)
	);

	bmp_outreg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.bus      (bus),
		.out_free (out_free),
		.out_ch   (out_ch)
	);

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams BMP files byte by byte into bmp24_stream_to_rgb565 and checks every
// pixel and header-reject word against an in-bench decoder. Directed files
// cover header rejects, empty and huge images, row order and cropping; random
// files follow under several screen sizes with random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;
	import bmp_pkg::*;

	localparam int          ITEMS       = 1950;
	localparam int          NCFG        = 7;
	localparam int          SQUEEZE_CFG = 2;
	localparam int          HOLD_CYCLES = 400;
	localparam int          DRAIN       = 8;
	localparam int unsigned CYCLE_LIMIT = 800000;
	localparam logic [DIM_W-1:0] MAX_DIM = 11'd1024;

	localparam res_t HDR_REJECT = {KIND_ERROR, {COORD_W{1'b0}}, {COORD_W{1'b0}},
		{COLOR_W{1'b0}}};

	typedef struct packed {
		logic [15:0] sig;
		logic [31:0] off;
		logic [31:0] w;
		logic [31:0] h;
		logic [15:0] planes;
		logic [15:0] depth;
		logic [31:0] comp;
		int          body;
		logic        sof;
		int          err_at;
	} bmp_case_t;

	// body -1: whole image, at most 200 bytes; err_at >= 0: reject word typed in at that byte
	localparam int NDIR = 13;
	localparam bmp_case_t DIR_FILES [NDIR] = '{
		'{BMP_SIGNATURE, 54, 2, 2, BMP_PLANES, BMP_DEPTH, 0, -1, 1'b0, -1},
		'{16'h4D43, 54, 2, 2, BMP_PLANES, BMP_DEPTH, 0, 0, 1'b1, int'(IDX_SIG_HI)},
		'{BMP_SIGNATURE, 54, 2, 2, 16'd2, BMP_DEPTH, 0, 0, 1'b1, int'(IDX_PLN_HI)},
		'{BMP_SIGNATURE, 54, 2, 2, BMP_PLANES, 16'd32, 0, 0, 1'b1, int'(IDX_BPP_HI)},
		'{BMP_SIGNATURE, 54, 2, 2, BMP_PLANES, BMP_DEPTH, 32'h0100_0000, 0, 1'b1,
			int'(IDX_CMP_HI)},
		'{BMP_SIGNATURE, 0, 3, 2, BMP_PLANES, BMP_DEPTH, 0, -1, 1'b1, -1},
		'{BMP_SIGNATURE, 40, 2, -3, BMP_PLANES, BMP_DEPTH, 0, -1, 1'b1, -1},
		'{BMP_SIGNATURE, 54, 0, 2, BMP_PLANES, BMP_DEPTH, 0, 12, 1'b1, -1},
		'{BMP_SIGNATURE, 54, 32'h8000_0001, 2, BMP_PLANES, BMP_DEPTH, 0, 12, 1'b1, -1},
		'{BMP_SIGNATURE, 54, 2, 0, BMP_PLANES, BMP_DEPTH, 0, 12, 1'b1, -1},
		'{BMP_SIGNATURE, 54, 1, 32'h8000_0000, BMP_PLANES, BMP_DEPTH, 0, 24, 1'b1, -1},
		'{BMP_SIGNATURE, 54, 32'h7FFF_FFFF, 1, BMP_PLANES, BMP_DEPTH, 0, 30, 1'b1, -1},
		'{BMP_SIGNATURE, 54, 1, 250, BMP_PLANES, BMP_DEPTH, 0, 48, 1'b1, -1}
	};

	localparam logic [DIM_W-1:0] CFG_W [NCFG] = '{11'd1, 11'd0, 11'd2047, 11'd1024,
		11'd4, 11'd2, 11'd3};
	localparam logic [DIM_W-1:0] CFG_H [NCFG] = '{11'd1, 11'd7, 11'd2047, 11'd3,
		11'd0, 11'd3, 11'd2};

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	bmp_in_if  in_ch ();
	bmp_out_if out_ch ();

	bmp24_stream_to_rgb565 dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #10 clk = ~clk;

	// decoder state
	phase_t           p_phase;
	logic [31:0]      p_count;
	logic [31:0]      p_off;
	logic [31:0]      p_img_w;
	logic [31:0]      p_img_h;
	logic             p_top;
	logic [31:0]      p_row;
	logic [63:0]      p_rowb;
	logic [15:0]      p_held;
	logic [DIM_W-1:0] scr_w;
	logic [DIM_W-1:0] scr_h;

	res_t pending_words [$];
	res_t head_word;

	int   fails;
	int   live_bytes;
	int   bytes_sent;
	int   files_sent;
	int   pixels_seen;
	int   rejects_seen;
	int   cfg_count;
	bit   calm;
	bit   hold_req;
	int unsigned cycle_count;

	function automatic void parser_clear();
		p_phase = PH_HEADER;
		p_count = '0;
		p_off   = '0;
		p_img_w = '0;
		p_img_h = '0;
		p_top   = 1'b0;
		p_row   = '0;
		p_rowb  = '0;
		p_held  = '0;
	endfunction

	function automatic bit decode_byte(input logic [7:0] b, input logic sof,
			output res_t word);
		logic [31:0]      idx;
		logic [31:0]      mag;
		logic [31:0]      ypos;
		logic [4:0]       sh;
		logic [63:0]      row_len;
		logic [63:0]      col;
		logic [1:0]       lane;
		logic [DIM_W-1:0] wc;
		logic [DIM_W-1:0] hc;
		logic [15:0]      want;
		bit               hit;
		word = '0;
		hit = 1'b0;
		if (sof)
			parser_clear();
		if (p_phase != PH_DONE)
			live_bytes++;
		if (p_phase == PH_HEADER) begin
			idx = p_count;
			if (p_count != '1)
				p_count++;
			sh = {idx[1:0] - 2'd2, 3'b000};
			if (idx == IDX_SIG_LO || idx == IDX_PLN_LO || idx == IDX_BPP_LO) begin
				p_held = {8'h00, b};
			end else if (idx == IDX_SIG_HI || idx == IDX_PLN_HI || idx == IDX_BPP_HI) begin
				p_held = p_held | {b, 8'h00};
				want = (idx == IDX_SIG_HI) ? BMP_SIGNATURE :
					(idx == IDX_PLN_HI) ? BMP_PLANES : BMP_DEPTH;
				if (p_held != want) begin
					hit = 1'b1;
					word.kind = KIND_ERROR;
					p_phase = PH_DONE;
				end
			end else if (idx >= IDX_OFF_LO && idx <= IDX_OFF_HI) begin
				p_off = p_off | (32'(b) << sh);
			end else if (idx >= IDX_W_LO && idx <= IDX_W_HI) begin
				p_img_w = p_img_w | (32'(b) << sh);
			end else if (idx >= IDX_H_LO && idx <= IDX_H_HI) begin
				p_img_h = p_img_h | (32'(b) << sh);
			end else if (idx >= IDX_CMP_LO && idx <= IDX_CMP_HI) begin
				if (idx == IDX_CMP_LO)
					p_held = '0;
				if (b != 8'h00)
					p_held = 16'd1;
				if (idx == IDX_CMP_HI) begin
					if (p_held != '0) begin
						hit = 1'b1;
						word.kind = KIND_ERROR;
						p_phase = PH_DONE;
					end else begin
						p_held = '0;
						p_top = p_img_h[31];
						if (p_img_w == '0 || p_img_w[31] || p_img_h == '0)
							p_phase = PH_DONE;
						else if (p_off <= HEADER_LEN)
							p_phase = PH_PIXELS;
						else
							p_phase = PH_SKIP;
					end
				end
			end
		end else if (p_phase == PH_SKIP) begin
			idx = p_count;
			if (p_count != '1)
				p_count++;
			if (idx + 32'd1 >= p_off || idx == '1)
				p_phase = PH_PIXELS;
		end else if (p_phase == PH_PIXELS) begin
			row_len = ((64'(p_img_w) * 3) + 64'd3) & ~64'd3;
			lane = 2'(p_rowb % 3);
			col = p_rowb / 3;
			mag = p_top ? 32'd0 - p_img_h : p_img_h;
			if (p_rowb < 64'(p_img_w) * 3) begin
				if (lane == LANE_BLUE) begin
					p_held = {8'h00, b};
				end else if (lane == LANE_GREEN) begin
					p_held = {b, p_held[7:0]};
				end else begin
					wc = (scr_w > MAX_DIM) ? MAX_DIM : scr_w;
					hc = (scr_h > MAX_DIM) ? MAX_DIM : scr_h;
					ypos = p_top ? p_row : mag - 32'd1 - p_row;
					if (col < 64'(wc) && ypos < 32'(hc)) begin
						hit = 1'b1;
						word.kind    = KIND_PIXEL;
						word.pixel_x = col[COORD_W-1:0];
						word.pixel_y = ypos[COORD_W-1:0];
						word.color   = {b[7:3], p_held[15:10], p_held[7:3]};
					end
				end
			end
			p_rowb++;
			if (p_rowb >= row_len) begin
				p_rowb = '0;
				p_row++;
				if (p_row >= mag || p_row == '0)
					p_phase = PH_DONE;
			end
		end
		return hit;
	endfunction

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic sof, input bit tabled,
			input bit tab_err);
		int   gap;
		res_t word;
		bit   hit;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid         <= 1'b1;
		in_ch.data_byte     <= b;
		in_ch.start_of_file <= sof;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		bytes_sent++;
		hit = decode_byte(b, sof, word);
		if (tabled) begin
			if (tab_err)
				pending_words.push_back(HDR_REJECT);
		end else if (hit) begin
			pending_words.push_back(word);
		end
	endtask

	task automatic send_file(input bmp_case_t fc, input int noise);
		logic [7:0]      hdr [34];
		logic [31:0]     h_abs;
		longint unsigned mag;
		longint unsigned full;
		int              n_skip;
		int              n_body;
		bit              tabled;
		tabled = (fc.err_at >= 0);
		foreach (hdr[i])
			hdr[i] = 8'($urandom);
		hdr[IDX_SIG_LO] = fc.sig[7:0];
		hdr[IDX_SIG_HI] = fc.sig[15:8];
		for (int i = 0; i < 2; i++) begin
			hdr[IDX_PLN_LO + i] = fc.planes[8*i +: 8];
			hdr[IDX_BPP_LO + i] = fc.depth[8*i +: 8];
		end
		for (int i = 0; i < 4; i++) begin
			hdr[IDX_OFF_LO + i] = fc.off[8*i +: 8];
			hdr[IDX_W_LO + i]   = fc.w[8*i +: 8];
			hdr[IDX_H_LO + i]   = fc.h[8*i +: 8];
			hdr[IDX_CMP_LO + i] = fc.comp[8*i +: 8];
		end
		h_abs = fc.h[31] ? 32'd0 - fc.h : fc.h;
		mag = 64'(h_abs);
		full = ((64'(fc.w) * 3 + 64'd3) & ~64'd3) * mag;
		n_body = (fc.body >= 0) ? fc.body : ((full > 200) ? 200 : int'(full));
		n_skip = (fc.off > HEADER_LEN && fc.off < 100) ? int'(fc.off) - 34 : 0;
		files_sent++;
		foreach (hdr[i])
			send_byte(hdr[i], (i == 0) ? fc.sof : 1'b0, tabled, tabled && i == fc.err_at);
		repeat (n_skip + n_body)
			send_byte(8'($urandom), 1'b0, tabled, 1'b0);
		repeat (noise)
			send_byte(8'($urandom), 1'b0, tabled, 1'b0);
	endtask

	task automatic random_file(input bit squeeze);
		bmp_case_t fc;
		int        r;
		fc.sig    = BMP_SIGNATURE;
		fc.planes = BMP_PLANES;
		fc.depth  = BMP_DEPTH;
		fc.comp   = '0;
		fc.off    = ($urandom_range(0, 9) < 7) ? 32'd54 : 32'($urandom_range(0, 60));
		fc.w      = $urandom_range(1, 6);
		fc.h      = $urandom_range(1, 5);
		if ($urandom_range(0, 1))
			fc.h = -fc.h;
		fc.body   = ($urandom_range(0, 99) < 15) ? $urandom_range(0, 40) : -1;
		fc.sof    = ($urandom_range(0, 19) != 0);
		fc.err_at = -1;
		r = $urandom_range(0, 99);
		if (r < 3) begin
			fc.w = '0;
		end else if (r < 5) begin
			fc.w = {1'b1, 31'($urandom)};
			fc.body = $urandom_range(0, 12);
		end else if (r < 7) begin
			fc.h = '0;
		end else if (r < 10) begin
			fc.sig = 16'($urandom);
		end else if (r < 12) begin
			fc.planes = 16'($urandom_range(0, 3));
		end else if (r < 14) begin
			fc.depth = 16'($urandom_range(0, 32));
		end else if (r < 16) begin
			fc.comp = 32'd1 << $urandom_range(0, 31);
		end
		if (squeeze) begin
			fc = '{BMP_SIGNATURE, 54, 6, 5, BMP_PLANES, BMP_DEPTH, 0, -1, 1'b1, -1};
			calm = 1'b1;
			hold_req = 1'b1;
		end
		send_file(fc, ($urandom_range(0, 99) < 15) ? $urandom_range(1, 10) : 0);
	endtask

	task automatic settle();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (pending_words.size() != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	task automatic apb_write(input logic reg_idx, input logic [DIM_W-1:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_idx, 2'b00};
		pwdata  <= {21'($urandom), val};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (reg_idx == REG_SCREEN_W)
			scr_w = val;
		else
			scr_h = val;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$error("timeout after %0d cycles, %0d words outstanding", cycle_count,
				pending_words.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_ch.valid && out_ch.ready) begin
			if (pending_words.size() == 0) begin
				$error("unexpected word: kind %0d x %0d y %0d color %h", out_ch.kind,
					out_ch.pixel_x, out_ch.pixel_y, out_ch.color);
				fails++;
			end else begin
				head_word = pending_words.pop_front();
				if (out_ch.kind !== head_word.kind) begin
					$error("kind: expected %0d, got %0d", head_word.kind, out_ch.kind);
					fails++;
				end
				if (out_ch.pixel_x !== head_word.pixel_x) begin
					$error("pixel_x: expected %0d, got %0d", head_word.pixel_x,
						out_ch.pixel_x);
					fails++;
				end
				if (out_ch.pixel_y !== head_word.pixel_y) begin
					$error("pixel_y: expected %0d, got %0d", head_word.pixel_y,
						out_ch.pixel_y);
					fails++;
				end
				if (out_ch.color !== head_word.color) begin
					$error("color: expected %h, got %h", head_word.color, out_ch.color);
					fails++;
				end
				if (head_word.kind == KIND_ERROR)
					rejects_seen++;
				else
					pixels_seen++;
			end
		end
	end

	initial begin : sink_side
		int hold_left;
		int gap_left;
		hold_left = 0;
		gap_left = 0;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				out_ch.ready <= 1'b0;
				hold_left--;
			end else if (gap_left > 0) begin
				out_ch.ready <= 1'b0;
				gap_left--;
			end else begin
				out_ch.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					gap_left = pick_gap();
			end
		end
	end

	initial begin : source_side
		int budget;
		int target;
		arst_n              <= 1'b0;
		in_ch.valid         <= 1'b0;
		in_ch.data_byte     <= '0;
		in_ch.start_of_file <= 1'b0;
		psel                <= 1'b0;
		penable             <= 1'b0;
		pwrite              <= 1'b0;
		paddr               <= '0;
		pwdata              <= '0;
		fails = 0;
		live_bytes = 0;
		bytes_sent = 0;
		files_sent = 0;
		pixels_seen = 0;
		rejects_seen = 0;
		cfg_count = 1;
		calm = 1'b0;
		hold_req = 1'b0;
		cycle_count = 0;
		scr_w = SCREEN_W_RST;
		scr_h = SCREEN_H_RST;
		parser_clear();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (DIR_FILES[i])
			send_file(DIR_FILES[i], 0);

		budget = (ITEMS - bytes_sent) / NCFG;
		for (int p = 0; p < NCFG; p++) begin
			settle();
			if (p == NCFG - 1) begin
				apb_write(REG_SCREEN_W, 11'($urandom_range(1, 8)));
				apb_write(REG_SCREEN_H, 11'($urandom_range(1, 8)));
			end else begin
				apb_write(REG_SCREEN_W, CFG_W[p]);
				apb_write(REG_SCREEN_H, CFG_H[p]);
			end
			cfg_count++;
			target = bytes_sent + budget;
			for (int n = 0; bytes_sent < target; n++) begin
				calm = ($urandom_range(0, 3) == 0);
				if ($urandom_range(0, 99) < 3 && !(p == SQUEEZE_CFG && n == 0))
					repeat ($urandom_range(1, 20))
						send_byte(8'($urandom), $urandom_range(0, 7) == 0, 1'b0, 1'b0);
				else
					random_file(p == SQUEEZE_CFG && n == 0);
			end
		end
		calm = 1'b0;
		settle();

		$display("Streamed %0d files, %0d bytes (%0d parsed) under %0d screen sizes.",
			files_sent, bytes_sent, live_bytes, cfg_count);
		$display("Checked %0d pixel words and %0d header rejects.", pixels_seen,
			rejects_seen);
		if (fails == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
